@@ hdl/dq_pkg.sv @@
// Shared constants, request and status codes, index helpers for the deque.
package dq_pkg;

   localparam int DEPTH    = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LIST_FWD   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_LIST_BWD   = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] idx_step(input logic [IDX_W-1:0] idx,
                                                 input logic             back);
      return back ? idx_dec(idx) : idx_inc(idx);
   endfunction

endpackage

@@ hdl/dq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit words in a 32-slot ring buffer memory.
// Each request transaction pushes or pops at either end or lists the contents in
// either direction; every request gives one or more response transactions, the final
// one with rsp_last set. Push, unused codes and pops or lists on an empty queue are
// answered directly by the response register. Pops and lists read through the single
// read port of the slot memory, whose registered read data then loads the response
// register, streaming one word per cycle while responses are taken. A push on a full
// queue is dropped with status full. The slot memory needs no clearing after reset.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [REQ_W-1:0]           req_type,
   input  logic signed [DATA_W-1:0]   req_push_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_data_value,
   output logic                       rsp_last
);

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic                     dir_back_ff, dir_back_in;
   logic                     pending_ff, pending_in;
   logic                     pend_last_ff, pend_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_value_ff, rsp_data_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     q_empty, q_full;
   logic [IDX_W-1:0]         back_idx, tail_idx;
   logic                     start_run, run_back;
   logic [CNT_W-1:0]         run_len;
   logic [IDX_W-1:0]         run_start;
   logic [STATUS_W-1:0]      direct_status;

   logic                     out_free, req_accept, issue, load_pend;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic [DATA_W-1:0]        rd_data;

   dq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DATA_W'(req_push_value)),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request decode
   always_comb begin
      q_empty       = (count_ff == '0);
      q_full        = (count_ff == CNT_W'(DEPTH));
      back_idx      = idx_add(front_ff, count_ff - 1'b1);
      tail_idx      = idx_add(front_ff, count_ff);
      start_run     = 1'b0;
      run_back      = 1'b0;
      run_len       = CNT_W'(1);
      run_start     = front_ff;
      direct_status = STAT_OK;
      unique case (req_type) inside
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            direct_status = q_full ? STAT_FULL : STAT_OK;
         end
         REQ_POP_FRONT: begin
            start_run     = !q_empty;
            direct_status = STAT_EMPTY;
         end
         REQ_POP_BACK: begin
            start_run     = !q_empty;
            run_start     = back_idx;
            direct_status = STAT_EMPTY;
         end
         REQ_LIST_FWD: begin
            start_run     = !q_empty;
            run_len       = count_ff;
            direct_status = STAT_EMPTY;
         end
         REQ_LIST_BWD: begin
            start_run     = !q_empty;
            run_len       = count_ff;
            run_start     = back_idx;
            run_back      = 1'b1;
            direct_status = STAT_EMPTY;
         end
         default: begin
            direct_status = STAT_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && start_run) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rem_ff == '0 && (!pending_ff || out_free)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      req_ready  = 1'b0;
      issue      = 1'b0;
      rd_addr    = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            issue     = req_valid && out_free && start_run;
            rd_addr   = run_start;
         end
         ST_RUN: begin
            issue = (rem_ff != '0) && (!pending_ff || out_free);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      req_accept = req_valid && req_ready;
      load_pend  = pending_ff && out_free;
   end

   // queue pointers and slot writes
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_idx;
      if (req_accept) begin
         case (req_type)
            REQ_PUSH_FRONT: begin
               if (!q_full) begin
                  front_in = idx_dec(front_ff);
                  wr_addr  = idx_dec(front_ff);
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_PUSH_BACK: begin
               if (!q_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_POP_FRONT: begin
               if (!q_empty) begin
                  front_in = idx_inc(front_ff);
                  count_in = count_ff - 1'b1;
               end
            end
            REQ_POP_BACK: begin
               if (!q_empty) begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // read run and response register
   always_comb begin
      ptr_in            = ptr_ff;
      rem_in            = rem_ff;
      dir_back_in       = dir_back_ff;
      pend_last_in      = pend_last_ff;
      pending_in        = pending_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_data_value_in = rsp_data_value_ff;
      rsp_last_in       = rsp_last_ff;

      if (issue) begin
         if (state_ff == ST_IDLE) begin
            ptr_in       = idx_step(run_start, run_back);
            rem_in       = run_len - 1'b1;
            dir_back_in  = run_back;
            pend_last_in = (run_len == CNT_W'(1));
         end else begin
            ptr_in       = idx_step(ptr_ff, dir_back_ff);
            rem_in       = rem_ff - 1'b1;
            pend_last_in = (rem_ff == CNT_W'(1));
         end
         pending_in = 1'b1;
      end else if (load_pend) begin
         pending_in = 1'b0;
      end

      if (req_accept && !start_run) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = direct_status;
         rsp_data_value_in = '0;
         rsp_last_in       = 1'b1;
      end else if (load_pend) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = STAT_OK;
         rsp_data_value_in = $signed(rd_data);
         rsp_last_in       = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff            <= ptr_in;
      dir_back_ff       <= dir_back_in;
      pend_last_ff      <= pend_last_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_data_value_ff <= rsp_data_value_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_value = rsp_data_value_ff;
   assign rsp_last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds queue depth");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_valid_ff || state_ff == ST_RUN))
      else $error("accepted request produced neither response nor read run");

   a_pending_run: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (state_ff == ST_RUN))
      else $error("read data pending outside a read run");

endmodule

@@ tb/double_ended_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: deque mirror, bursty sender, stalling receiver.
module double_ended_queue_tb
   import dq_pkg::*;
();

   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
   localparam int TOTAL_REQS   = 260;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 40;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [REQ_W-1:0]         kind;
      logic signed [DATA_W-1:0] word;
   } deque_req_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } deque_rsp_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] req_push_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_data_value;
   logic                     rsp_last;

   double_ended_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_value (rsp_data_value),
      .rsp_last       (rsp_last)
   );

   deque_req_type pending_reqs[$];
   deque_rsp_type expected_rsps[$];

   logic signed [DATA_W-1:0] mirror_slots [DEPTH];
   logic [IDX_W-1:0]         mirror_front;
   logic [CNT_W-1:0]         mirror_count;

   logic req_taken;
   int   accepted_reqs;
   int   checked_rsps;
   int   errors;
   int   full_hits;
   int   empty_hits;
   int   deepest_fill;
   int   longest_list;
   int   idle_cycles;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("mismatch on response %0d: %s got %h want %h", checked_rsps, what, got, want);
      errors++;
   endtask

   function automatic logic [IDX_W-1:0] ring_slot(input int off);
      return IDX_W'((int'(mirror_front) + off) % DEPTH);
   endfunction

   task automatic push_rsp(input logic [STATUS_W-1:0] status,
                           input logic signed [DATA_W-1:0] data, input logic last);
      deque_rsp_type r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      expected_rsps.push_back(r);
   endtask

   task automatic predict_deque_op(input logic [REQ_W-1:0] kind,
                                   input logic signed [DATA_W-1:0] word);
      int n;
      int off;
      n = int'(mirror_count);
      case (kind)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (n == DEPTH) begin
               push_rsp(STAT_FULL, '0, 1'b1);
               full_hits++;
            end else begin
               if (kind == REQ_PUSH_FRONT) begin
                  mirror_front = IDX_W'((int'(mirror_front) + DEPTH - 1) % DEPTH);
                  mirror_slots[mirror_front] = word;
               end else begin
                  mirror_slots[ring_slot(n)] = word;
               end
               mirror_count = mirror_count + 1'b1;
               if (n + 1 > deepest_fill) deepest_fill = n + 1;
               push_rsp(STAT_OK, '0, 1'b1);
            end
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (n == 0) begin
               push_rsp(STAT_EMPTY, '0, 1'b1);
               empty_hits++;
            end else begin
               if (kind == REQ_POP_FRONT) begin
                  push_rsp(STAT_OK, mirror_slots[mirror_front], 1'b1);
                  mirror_front = ring_slot(1);
               end else begin
                  push_rsp(STAT_OK, mirror_slots[ring_slot(n - 1)], 1'b1);
               end
               mirror_count = mirror_count - 1'b1;
            end
         end
         REQ_LIST_FWD, REQ_LIST_BWD: begin
            if (n == 0) begin
               push_rsp(STAT_EMPTY, '0, 1'b1);
               empty_hits++;
            end else begin
               for (int i = 0; i < n; i++) begin
                  off = (kind == REQ_LIST_FWD) ? i : n - 1 - i;
                  push_rsp(STAT_OK, mirror_slots[ring_slot(off)], i == n - 1);
               end
               if (n > longest_list) longest_list = n;
            end
         end
         default: push_rsp(STAT_OK, '0, 1'b1);
      endcase
   endtask

   task automatic add_req(input logic [REQ_W-1:0] kind, input logic signed [DATA_W-1:0] word);
      deque_req_type r;
      r.kind = kind;
      r.word = word;
      pending_reqs.push_back(r);
   endtask

   function automatic logic signed [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 15))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Request side: predict on acceptance. Response side: compare against the oldest prediction.
   always @(posedge clock) begin : watch_ports
      deque_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         mirror_front = '0;
         mirror_count = '0;
         foreach (mirror_slots[i]) mirror_slots[i] = '0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_deque_op(req_type, req_push_value);
            accepted_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with nothing outstanding", rsp_data_value, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
               if (rsp_data_value !== want.data)
                  report_mismatch("data_value", rsp_data_value, want.data);
               if (rsp_last !== want.last)
                  report_mismatch("last", DATA_W'(rsp_last), DATA_W'(want.last));
            end
            checked_rsps++;
         end
      end
   end

   always @(negedge clock) begin : drive_req
      deque_req_type item;
      int burst_left;
      int gap_left;
      if (reset) begin
         req_valid      <= 1'b0;
         req_type       <= '0;
         req_push_value <= '0;
         burst_left = $urandom_range(1, 30);
         gap_left = 0;
      end else if (!(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            item = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_type       <= item.kind;
            req_push_value <= item.word;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                      : $urandom_range(0, 2);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_rsp
      int hold_left;
      int window_left;
      int ready_mode;
      bit hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         window_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
         rsp_ready <= 1'b0;
         hold_left = HOLD_CYCLES - 1;
         hold_done = 1'b1;
      end else begin
         if (window_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            window_left = $urandom_range(8, 64);
         end
         window_left--;
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (window_left % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     idle_cycles, expected_rsps.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase;
      int len;
      int pick;
      logic [REQ_W-1:0] kind;
      reset = 1'b1;

      add_req(REQ_POP_FRONT, rand_word());
      add_req(REQ_POP_BACK, rand_word());
      add_req(REQ_LIST_FWD, rand_word());
      add_req(REQ_LIST_BWD, rand_word());
      add_req(REQ_SPARE_A, rand_word());
      add_req(REQ_SPARE_B, rand_word());
      add_req(REQ_PUSH_BACK, 32'sh7fffffff);
      add_req(REQ_PUSH_FRONT, 32'sh80000000);
      add_req(REQ_PUSH_BACK, 32'sh00000000);
      add_req(REQ_PUSH_FRONT, 32'shffffffff);
      add_req(REQ_PUSH_BACK, 32'shaaaaaaaa);
      add_req(REQ_PUSH_FRONT, 32'sh55555555);
      add_req(REQ_LIST_FWD, '0);
      add_req(REQ_LIST_BWD, '0);
      repeat (3) begin
         add_req(REQ_POP_FRONT, '0);
         add_req(REQ_POP_BACK, '0);
      end
      add_req(REQ_POP_BACK, '0);
      add_req(REQ_PUSH_FRONT, 32'sh00000001);
      add_req(REQ_POP_BACK, '0);
      add_req(REQ_PUSH_BACK, 32'sh00000002);
      add_req(REQ_POP_FRONT, '0);

      // fill past capacity, then list the full queue both ways
      repeat (DEPTH + 2) add_req($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                                 rand_word());
      add_req(REQ_LIST_FWD, rand_word());
      add_req(REQ_LIST_BWD, rand_word());

      while (pending_reqs.size() < TOTAL_REQS) begin
         pick = $urandom_range(0, 19);
         phase = (pick < 7) ? 0 : (pick < 13) ? 1 : (pick < 18) ? 2 : 3;
         len = (phase == 3) ? $urandom_range(2, 8) : $urandom_range(4, 40);
         repeat (len) begin
            pick = $urandom_range(0, 9);
            case (phase)
               0: begin
                  if (pick < 8) begin
                     kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                  end else begin
                     kind = $urandom_range(0, 1) ? REQ_LIST_BWD : REQ_LIST_FWD;
                  end
               end
               1: begin
                  if (pick < 8) begin
                     kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
                  end else begin
                     kind = $urandom_range(0, 1) ? REQ_LIST_BWD : REQ_LIST_FWD;
                  end
               end
               2: kind = 3'($urandom_range(0, 5));
               default: kind = 3'($urandom_range(0, 7));
            endcase
            if (pending_reqs.size() < TOTAL_REQS) add_req(kind, rand_word());
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (accepted_reqs < TOTAL_REQS || expected_rsps.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d responses, %0d full-queue pushes, %0d empty",
               accepted_reqs, checked_rsps, full_hits, empty_hits);
      $display("deepest fill %0d of %0d, longest listing %0d words, one %0d-cycle hold-off",
               deepest_fill, DEPTH, longest_list, HOLD_CYCLES);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
